[src/fsf_pkg.sv]
package fsf_pkg;

  localparam int MAX_MEMBERS = 256;
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int POS_W       = 24;
  localparam int DIFF_W      = POS_W + 1;
  localparam int SUM_W       = DIFF_W + $clog2(MAX_MEMBERS) + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int RAD_W       = 23;
  localparam int MAXS_W      = 16;
  localparam int FORCE_W     = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 23;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEP    = 2'd1;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_SQX   = 4'd2,
    OP_SQY   = 4'd3,
    OP_SQR   = 4'd4,
    OP_CMP   = 4'd5,
    OP_MAG   = 4'd6,
    OP_NORM  = 4'd7,
    OP_SA    = 4'd8,
    OP_SB    = 4'd9,
    OP_SSUM  = 4'd10,
    OP_MA    = 4'd11,
    OP_MSQ   = 4'd12,
    OP_DINIT = 4'd13,
    OP_DIV   = 4'd14,
    OP_SINIT = 4'd15
  } op_base_t;

  typedef struct packed {
    op_base_t op;
    logic     sqrt_step;
    logic     store_q;
    logic     emit;
    logic     comp;
  } fsf_cmd_t;

  typedef struct packed {
    logic last;
    logic big;
    logic step_last_div;
    logic step_last_sqrt;
    logic out_free;
  } fsf_stat_t;

endpackage

[src/fsf_in_if.sv]
interface fsf_in_if;
  import fsf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] self_x;
  logic signed [POS_W-1:0] self_y;
  logic signed [POS_W-1:0] other_x;
  logic signed [POS_W-1:0] other_y;
  logic                    is_self;
  logic                    last_member;
  modport source (output valid, self_x, self_y, other_x, other_y, is_self, last_member,
                  input ready);
  modport sink (input valid, self_x, self_y, other_x, other_y, is_self, last_member,
                output ready);
endinterface

[src/fsf_out_if.sv]
interface fsf_out_if;
  import fsf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  modport source (output valid, force_x, force_y, input ready);
  modport sink (input valid, force_x, force_y, output ready);
endinterface

[src/fsf_cfg_if.sv]
interface fsf_cfg_if;
  import fsf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/fsf_ctrl.sv]
module fsf_ctrl
  import fsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fsf_stat_t stat,
  output fsf_cmd_t  cmd
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_SQX   = 17'h00002,
    ST_SQY   = 17'h00004,
    ST_SQR   = 17'h00008,
    ST_CMP   = 17'h00010,
    ST_MAG   = 17'h00020,
    ST_NORM  = 17'h00040,
    ST_SB    = 17'h00080,
    ST_SSUM  = 17'h00100,
    ST_MA    = 17'h00200,
    ST_MSQ   = 17'h00400,
    ST_DINIT = 17'h00800,
    ST_DIV   = 17'h01000,
    ST_SINIT = 17'h02000,
    ST_SQRT  = 17'h04000,
    ST_STQ   = 17'h08000,
    ST_OUT   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic   comp_r, comp_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    comp_nxt      = comp_r;
    cmd.op        = OP_NONE;
    cmd.sqrt_step = 1'b0;
    cmd.store_q   = 1'b0;
    cmd.emit      = 1'b0;
    cmd.comp      = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        cmd.op    = OP_SQY;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.op    = OP_SQR;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = stat.last ? ST_MAG : ST_IDLE;
      end
      ST_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.big) begin
          cmd.op = OP_NORM;
        end else begin
          cmd.op    = OP_SA;
          state_nxt = ST_SB;
        end
      end
      ST_SB: begin
        cmd.op    = OP_SB;
        state_nxt = ST_SSUM;
      end
      ST_SSUM: begin
        cmd.op    = OP_SSUM;
        comp_nxt  = 1'b0;
        state_nxt = ST_MA;
      end
      ST_MA: begin
        cmd.op    = OP_MA;
        state_nxt = ST_MSQ;
      end
      ST_MSQ: begin
        cmd.op    = OP_MSQ;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.op    = OP_DINIT;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (stat.step_last_div) begin
          state_nxt = ST_SINIT;
        end
      end
      ST_SINIT: begin
        cmd.op    = OP_SINIT;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.step_last_sqrt) begin
          state_nxt = ST_STQ;
        end
      end
      ST_STQ: begin
        cmd.store_q = 1'b1;
        if (comp_r) begin
          state_nxt = ST_OUT;
        end else begin
          comp_nxt  = 1'b1;
          state_nxt = ST_MA;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      comp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // result only after the last member has been through the compare
  a_emit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && !stat.last) |=> (state_r == ST_IDLE))
    else $error("query closed without last member");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (state_r == ST_IDLE))
    else $error("item taken while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result emitted into a full output register");

endmodule

[src/fsf_datapath.sv]
module fsf_datapath
  import fsf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  fsf_cmd_t                  cmd,
  output fsf_stat_t                 stat,
  input  logic signed [POS_W-1:0]   self_x,
  input  logic signed [POS_W-1:0]   self_y,
  input  logic signed [POS_W-1:0]   other_x,
  input  logic signed [POS_W-1:0]   other_y,
  input  logic                      is_self,
  input  logic                      last_member,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FORCE_W-1:0] force_x,
  output logic signed [FORCE_W-1:0] force_y
);

  logic [RAD_W-1:0]         radius_r;
  logic [MAXS_W-1:0]        maxsep_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [POS_W-1:0]         adx_r, ady_r;
  logic                     skip_r, last_r;
  logic [63:0]              prod_r;
  logic [48:0]              d2_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [MAG_W-1:0]         a_r, b_r;
  logic [32:0]              s_r;
  logic [32:0]              rem_r;
  logic [31:0]              n_r;
  logic [16:0]              srem_r;
  logic [15:0]              root_r;
  logic [4:0]               step_r;
  logic [15:0]              qx_r, qy_r;
  logic                     out_valid_r;
  logic signed [FORCE_W-1:0] fx_r, fy_r;

  logic signed [DIFF_W-1:0] dx_w, dy_w;
  logic [31:0]              mul_a, mul_b;
  logic [63:0]              mul_p;
  logic [33:0]              div_w;
  logic                     div_ge;
  logic [18:0]              sq_w;
  logic [18:0]              sq_trial;
  logic                     sq_ge;
  logic [15:0]              q_w;
  logic [FORCE_W-1:0]       qx_ext, qy_ext;

  assign dx_w = DIFF_W'(other_x) - DIFF_W'(self_x);
  assign dy_w = DIFF_W'(other_y) - DIFF_W'(self_y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQX: begin
        mul_a = 32'(adx_r);
        mul_b = 32'(adx_r);
      end
      OP_SQY: begin
        mul_a = 32'(ady_r);
        mul_b = 32'(ady_r);
      end
      OP_SQR: begin
        mul_a = 32'(radius_r);
        mul_b = 32'(radius_r);
      end
      OP_SA: begin
        mul_a = 32'(a_r[15:0]);
        mul_b = 32'(a_r[15:0]);
      end
      OP_SB: begin
        mul_a = 32'(b_r[15:0]);
        mul_b = 32'(b_r[15:0]);
      end
      OP_MA: begin
        mul_a = 32'(maxsep_r);
        mul_b = cmd.comp ? 32'(b_r[15:0]) : 32'(a_r[15:0]);
      end
      OP_MSQ: begin
        mul_a = prod_r[31:0];
        mul_b = prod_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_w  = {rem_r, n_r[31]};
  assign div_ge = (div_w >= {1'b0, s_r});

  assign sq_w     = {srem_r, n_r[31:30]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_w >= sq_trial);

  assign q_w    = (s_r == '0) ? '0 : root_r;
  assign qx_ext = FORCE_W'(qx_r);
  assign qy_ext = FORCE_W'(qy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      maxsep_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SEP_RADIUS) begin
        radius_r <= cfg_data[RAD_W-1:0];
      end else if (cfg_index == REG_MAX_SEP) begin
        maxsep_r <= cfg_data[MAXS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CMP && !skip_r && ({15'd0, d2_r} <= prod_r)
          && cnt_r < CNT_W'(MAX_MEMBERS)) begin
        sum_x_r <= sum_x_r + SUM_W'(dx_r);
        sum_y_r <= sum_y_r + SUM_W'(dy_r);
        cnt_r   <= cnt_r + 1'b1;
      end
      if (cmd.emit) begin
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dx_r   <= dx_w;
        dy_r   <= dy_w;
        adx_r  <= dx_w[DIFF_W-1] ? POS_W'(-dx_w) : POS_W'(dx_w);
        ady_r  <= dy_w[DIFF_W-1] ? POS_W'(-dy_w) : POS_W'(dy_w);
        skip_r <= is_self;
        last_r <= last_member;
      end
      OP_SQX: prod_r <= mul_p;
      OP_SQY: begin
        d2_r   <= 49'(prod_r[47:0]);
        prod_r <= mul_p;
      end
      OP_SQR: begin
        d2_r   <= d2_r + 49'(prod_r[47:0]);
        prod_r <= mul_p;
      end
      OP_MAG: begin
        a_r <= sum_x_r[SUM_W-1] ? MAG_W'(-sum_x_r) : MAG_W'(sum_x_r);
        b_r <= sum_y_r[SUM_W-1] ? MAG_W'(-sum_y_r) : MAG_W'(sum_y_r);
      end
      OP_NORM: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
      end
      OP_SA: prod_r <= mul_p;
      OP_SB: begin
        s_r    <= 33'(prod_r[31:0]);
        prod_r <= mul_p;
      end
      OP_SSUM: s_r <= s_r + 33'(prod_r[31:0]);
      OP_MA:   prod_r <= mul_p;
      OP_MSQ:  prod_r <= mul_p;
      OP_DINIT: begin
        rem_r  <= 33'(prod_r[63:32]);
        n_r    <= prod_r[31:0];
        step_r <= '0;
      end
      OP_DIV: begin
        rem_r  <= div_ge ? 33'(div_w - {1'b0, s_r}) : div_w[32:0];
        n_r    <= {n_r[30:0], div_ge};
        step_r <= step_r + 1'b1;
      end
      OP_SINIT: begin
        srem_r <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      default: begin
      end
    endcase
    if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? 17'(sq_w - sq_trial) : sq_w[16:0];
      root_r <= {root_r[14:0], sq_ge};
      n_r    <= {n_r[29:0], 2'b00};
      step_r <= step_r + 1'b1;
    end
    if (cmd.store_q) begin
      if (cmd.comp) begin
        qy_r <= q_w;
      end else begin
        qx_r <= q_w;
      end
    end
    if (cmd.emit) begin
      fx_r <= (sum_x_r > 0) ? -qx_ext : qx_ext;
      fy_r <= (sum_y_r > 0) ? -qy_ext : qy_ext;
    end
  end

  assign stat.last           = last_r;
  assign stat.big            = ((a_r | b_r) >> 16) != '0;
  assign stat.step_last_div  = (step_r == 5'd31);
  assign stat.step_last_sqrt = (step_r == 5'd15);
  assign stat.out_free       = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign force_x   = fx_r;
  assign force_y   = fy_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_MEMBERS))
    else $error("neighbour count past limit");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (sum_x_r == '0 && sum_y_r == '0 && cnt_r == '0 && out_valid_r))
    else $error("accumulators not cleared after result");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && !cmd.emit) |=> (out_valid_r && $stable(fx_r)))
    else $error("stalled result changed");

endmodule

[src/flock_separation_force.sv]
// boids separation force for one follower
// in_ch carries one flock member per beat together with the follower position;
// the beat flagged last_member closes the query and one force leaves on out_ch
// cfg_ch writes separation_radius (index 0) and max_separation (index 1);
// cfg_ch.ready is always high, write only while the block is idle
// per member: one shared multiplier does dx^2, dy^2 and r^2 in turn, then
// compare and accumulate, before the block is ready again
// closing a query: after the last member's compare the sums are shifted down
// one bit at a time (up to 17 bits) until they fit in 16 bits, then the
// bit-serial 32 step divider and 16 step square root run once for each
// force component
// reset clears the radius, max separation, sums, count and output valid
// the result sits in an output register; the next query's members are taken
// while it waits, and a new result waits in place until the output register is empty or out_ch.ready is seen
module flock_separation_force
  import fsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  fsf_in_if.sink    in_ch,
  fsf_out_if.source out_ch,
  fsf_cfg_if.sink   cfg_ch
);

  fsf_cmd_t  cmd;
  fsf_stat_t stat;
  logic      in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  fsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .self_x      (in_ch.self_x),
    .self_y      (in_ch.self_y),
    .other_x     (in_ch.other_x),
    .other_y     (in_ch.other_y),
    .is_self     (in_ch.is_self),
    .last_member (in_ch.last_member),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .force_x     (out_ch.force_x),
    .force_y     (out_ch.force_y)
  );

endmodule
